/* src/ism_pkg.sv */
// Shared types, sizes and codes of the interval subscription matcher.
`timescale 1ns / 1ps
package ism_pkg;

    localparam int NUM_ATTR    = 32;
    localparam int SEGMENTS    = 16;
    localparam int MAX_SUBS    = 1024;
    localparam int MAX_ENTRIES = 4096;
    localparam int MAX_CONS    = 16;

    localparam int BUCKETS = NUM_ATTR * SEGMENTS;
    localparam int ATTR_W  = $clog2(NUM_ATTR);
    localparam int SUB_W   = $clog2(MAX_SUBS);
    localparam int ENT_W   = $clog2(MAX_ENTRIES);
    localparam int USED_W  = ENT_W + 1;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int CONS_W  = $clog2(MAX_CONS);
    localparam int PCNT_W  = CONS_W + 1;
    localparam int CTR_W   = PCNT_W + 1;
    localparam int CNT_W   = SUB_W + 1;
    localparam int MATCH_W = 11;
    localparam int VAL_W   = 16;

    typedef enum logic [1:0] {
        OP_FREQ = 2'd0,
        OP_CONS = 2'd1,
        OP_PAIR = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CLOSE, S_PV_RD, S_PV_CMP, S_ST_RD, S_ST_B, S_ST_W,
        S_SUB_RD, S_SUB_W, S_SWEEP, S_P_SCAN, S_P_BKT, S_P_ERD, S_P_ECHK,
        S_P_CNT, S_P_END, S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [SUB_W-1:0]  sub_id;
        logic [ATTR_W-1:0] attribute;
        logic [VAL_W-1:0]  low_value;
        logic [VAL_W-1:0]  high_value;
        logic [VAL_W-1:0]  pub_value;
        logic              last;
    } req_t;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [VAL_W-1:0]  lo;
        logic [VAL_W-1:0]  hi;
    } pend_t;

    typedef struct packed {
        logic [SUB_W-1:0]  sub;
        logic [ATTR_W-1:0] attr;
        logic [VAL_W-1:0]  lo;
        logic [VAL_W-1:0]  hi;
    } ent_t;

    typedef struct packed {
        logic             valid;
        logic [ENT_W-1:0] head;
        logic [ENT_W-1:0] tail;
    } bkt_t;

    typedef struct packed {
        logic [PCNT_W-1:0] size;
        logic [CTR_W-1:0]  ctr;
    } subw_t;

    function automatic logic [BKT_W-1:0] bkt_idx(input logic [ATTR_W-1:0] p,
                                                 input logic [ATTR_W-1:0] a);
        return BKT_W'(32'(p) * SEGMENTS + 32'(a) % SEGMENTS);
    endfunction

endpackage

/* src/ism_front.sv */
// Request queue between the input channel and the matching engine.
`timescale 1ns / 1ps
module ism_front
    import ism_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept_en,
    input  logic push_valid,
    output logic push_ready,
    input  req_t push_req,
    output logic req_valid,
    input  logic pop,
    output req_t req
);

    req_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2) && accept_en;
    assign push       = push_valid && push_ready;
    assign req_valid  = (fill_reg != 2'd0);
    assign do_pop     = pop && req_valid;
    assign req        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

/* src/ism_back.sv */
// Matching engine: stores, sequencer and result register.
`timescale 1ns / 1ps
module ism_back
    import ism_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  req_t               req,
    output logic               pop,
    output logic               accept_en,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MATCH_W-1:0] match_count,
    output logic               status
);

    state_t state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PCNT_W-1:0]  pcount_reg, pcount_next;
    logic               pbad_reg, pbad_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic               pub_reg, pub_next;
    logic [MATCH_W-1:0] matched_reg, matched_next;
    logic [VAL_W-1:0]   freq_reg [NUM_ATTR];
    logic [VAL_W-1:0]   freq_next [NUM_ATTR];
    logic [NUM_ATTR-1:0] flag_reg, flag_next;
    logic [PCNT_W-1:0]  idx_reg, idx_next;
    logic [ATTR_W-1:0]  pivot_reg, pivot_next;
    logic [VAL_W-1:0]   best_reg, best_next;
    logic [ATTR_W-1:0]  pp_reg, pp_next;
    logic [ENT_W-1:0]   e_reg, e_next;
    logic [1:0]         drop_reg, drop_next;
    req_t               cur_reg, cur_next;
    logic [MATCH_W-1:0] res_count_reg, res_count_next;
    logic               res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [MATCH_W-1:0] out_count_reg, out_count_next;
    logic               out_status_reg, out_status_next;

    pend_t pend_mem [MAX_CONS];
    ent_t  ent_mem [MAX_ENTRIES];
    logic [ENT_W-1:0] nxt_mem [MAX_ENTRIES];
    bkt_t  bkt_mem [BUCKETS];
    subw_t sub_mem [MAX_SUBS];

    pend_t pend_rdata_reg;
    ent_t  ent_rdata_reg;
    logic [ENT_W-1:0] nxt_rdata_reg;
    bkt_t  bkt_rdata_reg;
    subw_t sub_rdata_reg;

    logic pend_we, pend_re, sub_we, sub_re, bkt_we, bkt_re, ent_we, ent_re, nxt_we;
    logic [CONS_W-1:0] pend_waddr, pend_raddr;
    pend_t             pend_wdata;
    logic [SUB_W-1:0]  sub_waddr, sub_raddr;
    subw_t             sub_wdata;
    logic [BKT_W-1:0]  bkt_waddr, bkt_raddr;
    bkt_t              bkt_wdata;
    logic [ENT_W-1:0]  ent_waddr, nxt_waddr, nxt_wdata;
    ent_t              ent_wdata;

    logic adv, nextp;
    logic [ATTR_W-1:0] a_v, piv_v;
    logic [1:0] d_v;
    logic [CTR_W-1:0] c_v;

    assign accept_en   = (state_reg != S_CLEAR);
    assign out_valid   = out_valid_reg;
    assign match_count = out_count_reg;
    assign status      = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pcount_next     = pcount_reg;
        pbad_next       = pbad_reg;
        used_next       = used_reg;
        pub_next        = pub_reg;
        matched_next    = matched_reg;
        freq_next       = freq_reg;
        flag_next       = flag_reg;
        idx_next        = idx_reg;
        pivot_next      = pivot_reg;
        best_next       = best_reg;
        pp_next         = pp_reg;
        e_next          = e_reg;
        drop_next       = drop_reg;
        cur_next        = cur_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        pop        = 1'b0;
        pend_we    = 1'b0;
        pend_re    = 1'b0;
        pend_waddr = pcount_reg[CONS_W-1:0];
        pend_raddr = idx_reg[CONS_W-1:0];
        pend_wdata = '{attr: req.attribute, lo: req.low_value, hi: req.high_value};
        sub_we     = 1'b0;
        sub_re     = 1'b0;
        sub_waddr  = cur_reg.sub_id;
        sub_raddr  = cur_reg.sub_id;
        sub_wdata  = '0;
        bkt_we     = 1'b0;
        bkt_re     = 1'b0;
        bkt_waddr  = bkt_idx(pivot_reg, pend_rdata_reg.attr);
        bkt_raddr  = bkt_idx(pivot_reg, pend_rdata_reg.attr);
        bkt_wdata  = '0;
        ent_we     = 1'b0;
        ent_re     = 1'b0;
        ent_waddr  = used_reg[ENT_W-1:0];
        ent_wdata  = '{sub: cur_reg.sub_id, attr: pend_rdata_reg.attr,
                       lo: pend_rdata_reg.lo, hi: pend_rdata_reg.hi};
        nxt_we     = 1'b0;
        nxt_waddr  = bkt_rdata_reg.tail;
        nxt_wdata  = used_reg[ENT_W-1:0];
        adv   = 1'b0;
        nextp = 1'b0;
        a_v   = pend_rdata_reg.attr;
        piv_v = pivot_reg;
        d_v   = {1'b0, ent_rdata_reg.lo <= cur_reg.pub_value}
              + {1'b0, cur_reg.pub_value <= ent_rdata_reg.hi};
        c_v   = sub_rdata_reg.ctr;

        unique case (state_reg)
            S_CLEAR:
            begin
                // wipe subscription words and bucket heads, one row a cycle
                sub_we    = 1'b1;
                sub_waddr = cnt_reg[SUB_W-1:0];
                bkt_we    = 1'b1;
                bkt_waddr = cnt_reg[BKT_W-1:0];
                if (cnt_reg == CNT_W'(MAX_SUBS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pop      = 1'b1;
                    cur_next = req;
                    case (op_t'(req.operation))
                        OP_FREQ:
                        begin
                            if (freq_reg[req.attribute] != '1)
                            begin
                                freq_next[req.attribute] = freq_reg[req.attribute] + 1'b1;
                            end
                        end
                        OP_CONS:
                        begin
                            if (pcount_reg >= PCNT_W'(MAX_CONS))
                            begin
                                pbad_next = 1'b1;
                            end
                            else
                            begin
                                pend_we     = 1'b1;
                                pcount_next = pcount_reg + 1'b1;
                            end
                            if (req.last)
                            begin
                                state_next = S_CLOSE;
                            end
                        end
                        OP_PAIR:
                        begin
                            pp_next = '0;
                            if (!pub_reg)
                            begin
                                cnt_next     = '0;
                                matched_next = '0;
                                pub_next     = 1'b1;
                                state_next   = S_SWEEP;
                            end
                            else
                            begin
                                state_next = S_P_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CLOSE:
            begin
                idx_next = '0;
                if (pbad_reg || pcount_reg == '0 ||
                    USED_W'(pcount_reg) + used_reg > USED_W'(MAX_ENTRIES))
                begin
                    pcount_next     = '0;
                    pbad_next       = 1'b0;
                    res_count_next  = '0;
                    res_status_next = 1'b1;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_PV_RD;
                end
            end
            S_PV_RD:
            begin
                pend_re    = 1'b1;
                state_next = S_PV_CMP;
            end
            S_PV_CMP:
            begin
                if (idx_reg == '0 || freq_reg[a_v] < best_reg)
                begin
                    piv_v     = a_v;
                    best_next = freq_reg[a_v];
                end
                pivot_next = piv_v;
                if (idx_reg + 1'b1 == pcount_reg)
                begin
                    idx_next         = '0;
                    flag_next[piv_v] = 1'b1;
                    state_next       = S_ST_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PV_RD;
                end
            end
            S_ST_RD:
            begin
                pend_re    = 1'b1;
                state_next = S_ST_B;
            end
            S_ST_B:
            begin
                bkt_re     = 1'b1;
                state_next = S_ST_W;
            end
            S_ST_W:
            begin
                // append the entry at the tail of its bucket list
                ent_we = 1'b1;
                bkt_we = 1'b1;
                if (bkt_rdata_reg.valid)
                begin
                    nxt_we    = 1'b1;
                    bkt_wdata = '{valid: 1'b1, head: bkt_rdata_reg.head,
                                  tail: used_reg[ENT_W-1:0]};
                end
                else
                begin
                    bkt_wdata = '{valid: 1'b1, head: used_reg[ENT_W-1:0],
                                  tail: used_reg[ENT_W-1:0]};
                end
                used_next = used_reg + 1'b1;
                if (idx_reg + 1'b1 == pcount_reg)
                begin
                    state_next = S_SUB_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_ST_RD;
                end
            end
            S_SUB_RD:
            begin
                sub_re     = 1'b1;
                state_next = S_SUB_W;
            end
            S_SUB_W:
            begin
                sub_we    = 1'b1;
                sub_wdata = '{size: pcount_reg,
                              ctr: pub_reg ? {pcount_reg, 1'b0} : sub_rdata_reg.ctr};
                pcount_next = '0;
                pbad_next   = 1'b0;
                state_next  = S_IDLE;
            end
            S_SWEEP:
            begin
                // read row n while row n-1 gets twice its size
                if (cnt_reg != CNT_W'(MAX_SUBS))
                begin
                    sub_re    = 1'b1;
                    sub_raddr = cnt_reg[SUB_W-1:0];
                end
                if (cnt_reg != '0)
                begin
                    sub_we    = 1'b1;
                    sub_waddr = SUB_W'(cnt_reg - 1'b1);
                    sub_wdata = '{size: sub_rdata_reg.size,
                                  ctr: {sub_rdata_reg.size, 1'b0}};
                end
                if (cnt_reg == CNT_W'(MAX_SUBS))
                begin
                    state_next = S_P_SCAN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_P_SCAN:
            begin
                if (flag_reg[pp_reg])
                begin
                    bkt_re     = 1'b1;
                    bkt_raddr  = bkt_idx(pp_reg, cur_reg.attribute);
                    state_next = S_P_BKT;
                end
                else
                begin
                    nextp = 1'b1;
                end
            end
            S_P_BKT:
            begin
                if (bkt_rdata_reg.valid)
                begin
                    e_next     = bkt_rdata_reg.head;
                    state_next = S_P_ERD;
                end
                else
                begin
                    nextp = 1'b1;
                end
            end
            S_P_ERD:
            begin
                ent_re     = 1'b1;
                state_next = S_P_ECHK;
            end
            S_P_ECHK:
            begin
                if (ent_rdata_reg.attr == cur_reg.attribute && d_v != 2'd0)
                begin
                    sub_re     = 1'b1;
                    sub_raddr  = ent_rdata_reg.sub;
                    drop_next  = d_v;
                    state_next = S_P_CNT;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            S_P_CNT:
            begin
                sub_we    = 1'b1;
                sub_waddr = ent_rdata_reg.sub;
                sub_wdata = '{size: sub_rdata_reg.size,
                              ctr: (c_v > CTR_W'(drop_reg)) ? c_v - CTR_W'(drop_reg) : '0};
                if (c_v != '0 && c_v <= CTR_W'(drop_reg) && matched_reg != '1)
                begin
                    matched_next = matched_reg + 1'b1;
                end
                adv = 1'b1;
            end
            S_P_END:
            begin
                if (cur_reg.last)
                begin
                    pub_next        = 1'b0;
                    res_count_next  = matched_reg;
                    res_status_next = 1'b0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = res_count_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            if (e_reg == bkt_rdata_reg.tail)
            begin
                nextp = 1'b1;
            end
            else
            begin
                e_next     = nxt_rdata_reg;
                state_next = S_P_ERD;
            end
        end
        if (nextp)
        begin
            if (pp_reg == ATTR_W'(NUM_ATTR - 1))
            begin
                state_next = S_P_END;
            end
            else
            begin
                pp_next    = pp_reg + 1'b1;
                state_next = S_P_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            pcount_reg    <= '0;
            pbad_reg      <= 1'b0;
            used_reg      <= '0;
            pub_reg       <= 1'b0;
            matched_reg   <= '0;
            flag_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ATTR; i++)
            begin
                freq_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pcount_reg    <= pcount_next;
            pbad_reg      <= pbad_next;
            used_reg      <= used_next;
            pub_reg       <= pub_next;
            matched_reg   <= matched_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
            freq_reg      <= freq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pivot_reg      <= pivot_next;
        best_reg       <= best_next;
        pp_reg         <= pp_next;
        e_reg          <= e_next;
        drop_reg       <= drop_next;
        cur_reg        <= cur_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        if (pend_re)
        begin
            pend_rdata_reg <= pend_mem[pend_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re)
        begin
            ent_rdata_reg <= ent_mem[e_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        if (ent_re)
        begin
            nxt_rdata_reg <= nxt_mem[e_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        if (bkt_re)
        begin
            bkt_rdata_reg <= bkt_mem[bkt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sub_we)
        begin
            sub_mem[sub_waddr] <= sub_wdata;
        end
        if (sub_re)
        begin
            sub_rdata_reg <= sub_mem[sub_raddr];
        end
    end

endmodule

/* src/interval_subscription_matcher.sv */
// Top level of the interval subscription matcher.
`timescale 1ns / 1ps
// Usage: requests enter on in_valid/in_ready with the operation field choosing
// their meaning: frequency count, subscription constraint or publication pair.
// A two-entry request queue parts the input from the engine, so a request is
// taken while the engine works or while a result waits on out_valid/out_ready.
// Results: the last constraint of a rejected subscription gives status 1 with a
// zero count; the last pair of a publication gives its match count, status 0.
// Steps: the last constraint of a subscription picks the pivot, stores the
// entries and writes the subscription word, unless it is rejected at once.
// A pair scans every pivot, reads the bucket of each flagged pivot and walks
// the entries in its bucket lists, these held in block memories with one
// read and one write port; the last pair also loads its result and
// the first pair of a publication first loads every counter.
// Reset: a clearing pass wipes the subscription and bucket stores; in_ready
// stays low until it ends.
// Stall: while out_ready is low a finished result holds in the output register;
// the engine holds the next result until the register frees up, and the queue
// keeps taking requests until it is full.
module interval_subscription_matcher
    import ism_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [SUB_W-1:0]   sub_id,
    input  logic [ATTR_W-1:0]  attribute,
    input  logic [VAL_W-1:0]   low_value,
    input  logic [VAL_W-1:0]   high_value,
    input  logic [VAL_W-1:0]   pub_value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MATCH_W-1:0] match_count,
    output logic               status
);

    req_t in_req;
    req_t q_req;
    logic q_valid;
    logic q_pop;
    logic accept_en;

    // pack the request fields for the queue
    assign in_req = '{operation: operation, sub_id: sub_id, attribute: attribute,
                      low_value: low_value, high_value: high_value,
                      pub_value: pub_value, last: last};

    ism_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept_en  (accept_en),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_req   (in_req),
        .req_valid  (q_valid),
        .pop        (q_pop),
        .req        (q_req)
    );

    ism_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (q_valid),
        .req         (q_req),
        .pop         (q_pop),
        .accept_en   (accept_en),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .match_count (match_count),
        .status      (status)
    );

`ifndef SYNTHESIS
    // a rejection never carries a count
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> match_count == '0)
        else $error("rejection result with non-zero count");

    // no request is taken during the clearing pass
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        !accept_en |-> !in_ready)
        else $error("request taken while clearing");

    // the engine only drains the queue when it holds a request
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
`endif

endmodule

/* test/interval_subscription_matcher_checker.sv */
// Channel monitor, behavioural prediction and result comparison for the matcher.
`timescale 1ns / 1ps
module interval_subscription_matcher_checker
    import ism_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [SUB_W-1:0]   sub_id,
    input  logic [ATTR_W-1:0]  attribute,
    input  logic [VAL_W-1:0]   low_value,
    input  logic [VAL_W-1:0]   high_value,
    input  logic [VAL_W-1:0]   pub_value,
    input  logic               last,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [MATCH_W-1:0] match_count,
    input  logic               status,
    output int                 fail_count,
    output int                 outstanding
);

    typedef struct {
        logic [MATCH_W-1:0] count;
        logic               rejected;
    } outcome_t;

    outcome_t outcome_q[$];

    logic [15:0]       freq_tally[NUM_ATTR];
    bit                pivot_seen[NUM_ATTR];
    logic [ATTR_W-1:0] held_attr[MAX_CONS];
    logic [VAL_W-1:0]  held_lo[MAX_CONS];
    logic [VAL_W-1:0]  held_hi[MAX_CONS];
    int                held_count;
    bit                held_bad;
    logic [SUB_W-1:0]  ent_sub[MAX_ENTRIES];
    logic [ATTR_W-1:0] ent_attr[MAX_ENTRIES];
    logic [VAL_W-1:0]  ent_lo[MAX_ENTRIES];
    logic [VAL_W-1:0]  ent_hi[MAX_ENTRIES];
    int                ent_next[MAX_ENTRIES];
    int                ent_used;
    bit                bkt_live[BUCKETS];
    int                bkt_head[BUCKETS];
    int                bkt_tail[BUCKETS];
    logic [PCNT_W-1:0] sub_len[MAX_SUBS];
    logic [CTR_W-1:0]  sub_ctr[MAX_SUBS];
    int                match_tally;
    bit                pub_open;

    initial
    begin
        fail_count = 0;
        held_count = 0;
        held_bad = 0;
        ent_used = 0;
        match_tally = 0;
        pub_open = 0;
        foreach (freq_tally[i])
        begin
            freq_tally[i] = '0;
            pivot_seen[i] = 0;
        end
        foreach (bkt_live[i])
            bkt_live[i] = 0;
        foreach (sub_len[i])
        begin
            sub_len[i] = '0;
            sub_ctr[i] = '0;
        end
    end

    assign outstanding = outcome_q.size();

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic void drop_ctr(input int s);
        if (sub_ctr[s] == 0)
            return;
        sub_ctr[s]--;
        if (sub_ctr[s] == 0 && match_tally < 2047)
            match_tally++;
    endfunction

    function automatic bit store_subscription(input int s);
        int pivot;
        int b;
        int e;
        if (held_bad || held_count == 0 || held_count > MAX_ENTRIES - ent_used)
            return 0;
        pivot = held_attr[0];
        for (int i = 1; i < held_count; i++)
            if (freq_tally[held_attr[i]] < freq_tally[pivot])
                pivot = held_attr[i];
        pivot_seen[pivot] = 1;
        for (int i = 0; i < held_count; i++)
        begin
            e = ent_used++;
            b = pivot * SEGMENTS + held_attr[i] % SEGMENTS;
            ent_sub[e] = SUB_W'(s);
            ent_attr[e] = held_attr[i];
            ent_lo[e] = held_lo[i];
            ent_hi[e] = held_hi[i];
            ent_next[e] = 0;
            if (bkt_live[b])
                ent_next[bkt_tail[b]] = e;
            else
            begin
                bkt_live[b] = 1;
                bkt_head[b] = e;
            end
            bkt_tail[b] = e;
        end
        sub_len[s] = PCNT_W'(held_count);
        if (pub_open)
            sub_ctr[s] = CTR_W'(held_count * 2);
        return 1;
    endfunction

    function automatic void walk_pair(input int a, input logic [VAL_W-1:0] v);
        int b;
        int e;
        for (int p = 0; p < NUM_ATTR; p++)
        begin
            if (!pivot_seen[p])
                continue;
            b = p * SEGMENTS + a % SEGMENTS;
            if (!bkt_live[b])
                continue;
            e = bkt_head[b];
            for (int steps = 0; steps < MAX_ENTRIES && e < ent_used; steps++)
            begin
                if (ent_attr[e] == a)
                begin
                    if (ent_lo[e] <= v)
                        drop_ctr(ent_sub[e]);
                    if (v <= ent_hi[e])
                        drop_ctr(ent_sub[e]);
                end
                if (e == bkt_tail[b])
                    break;
                e = ent_next[e];
            end
        end
    endfunction

    function automatic void predict_request();
        outcome_t o;
        case (op_t'(operation))
            OP_FREQ:
            begin
                if (freq_tally[attribute] != 16'hFFFF)
                    freq_tally[attribute]++;
            end
            OP_CONS:
            begin
                if (held_count >= MAX_CONS)
                    held_bad = 1;
                else
                begin
                    held_attr[held_count] = attribute;
                    held_lo[held_count] = low_value;
                    held_hi[held_count] = high_value;
                    held_count++;
                end
                if (last)
                begin
                    if (!store_subscription(sub_id))
                    begin
                        o.count = '0;
                        o.rejected = 1'b1;
                        outcome_q = {outcome_q, o};
                    end
                    held_count = 0;
                    held_bad = 0;
                end
            end
            OP_PAIR:
            begin
                if (!pub_open)
                begin
                    foreach (sub_ctr[i])
                        sub_ctr[i] = {sub_len[i], 1'b0};
                    match_tally = 0;
                    pub_open = 1;
                end
                walk_pair(attribute, pub_value);
                if (last)
                begin
                    pub_open = 0;
                    o.count = MATCH_W'(match_tally);
                    o.rejected = 1'b0;
                    outcome_q = {outcome_q, o};
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_request();
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                    report($sformatf("unexpected result count=%0d status=%0d",
                                     match_count, status));
                else
                begin
                    if (match_count !== outcome_q[0].count)
                        report($sformatf("match_count %0d, predicted %0d",
                                         match_count, outcome_q[0].count));
                    if (status !== outcome_q[0].rejected)
                        report($sformatf("status %0d, predicted %0d",
                                         status, outcome_q[0].rejected));
                    void'(outcome_q.pop_front());
                end
            end
        end
    end

endmodule

/* test/interval_subscription_matcher_tb.sv */
// Stimulus, clocking and verdict for the interval subscription matcher.
`timescale 1ns / 1ps
module interval_subscription_matcher_tb;
    import ism_pkg::*;

    // Allow plenty of margin over the slowest legal run.
    localparam int CYCLE_LIMIT = 4000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         operation = '0;
    logic [SUB_W-1:0]   sub_id = '0;
    logic [ATTR_W-1:0]  attribute = '0;
    logic [VAL_W-1:0]   low_value = '0;
    logic [VAL_W-1:0]   high_value = '0;
    logic [VAL_W-1:0]   pub_value = '0;
    logic               last = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [MATCH_W-1:0] match_count;
    logic               status;

    int fail_count;
    int outstanding;
    int cycles = 0;
    int sent = 0;
    int burst_left = 0;
    bit steady = 0;
    int stall_left = 0;

    interval_subscription_matcher DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .sub_id(sub_id), .attribute(attribute),
        .low_value(low_value), .high_value(high_value), .pub_value(pub_value),
        .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .match_count(match_count), .status(status)
    );

    interval_subscription_matcher_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .sub_id(sub_id), .attribute(attribute),
        .low_value(low_value), .high_value(high_value), .pub_value(pub_value),
        .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .match_count(match_count), .status(status),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: abandon the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: accept freely, with occasional stalls of random length.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 15)
                stall_left = $urandom_range(1, 30);
        end
    end

    // Present one request and hold it until the handshake completes. Between
    // bursts, drop valid for a random gap unless running steady.
    task automatic send(input op_t op, input int sid, input int attr,
                        input int lo, input int hi, input int pv, input bit lst);
        if (!steady && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        if (!steady)
            burst_left--;
        in_valid   <= 1'b1;
        operation  <= op;
        sub_id     <= SUB_W'(sid);
        attribute  <= ATTR_W'(attr);
        low_value  <= VAL_W'(lo);
        high_value <= VAL_W'(hi);
        pub_value  <= VAL_W'(pv);
        last       <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // Attributes mostly from a narrow pool so that pairs meet stored entries;
    // the pool straddles 16 so different attributes share a bucket.
    function automatic int pick_attr();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, NUM_ATTR - 1);
        return ($urandom_range(0, 1) ? 16 : 0) + $urandom_range(0, 5);
    endfunction

    function automatic int pick_sub();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, MAX_SUBS - 1);
        return $urandom_range(0, 47);
    endfunction

    task automatic send_subscription(input int n, input int sid);
        int lo;
        int hi;
        for (int i = 0; i < n; i++)
        begin
            lo = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                           : $urandom_range(0, 30000);
            hi = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                           : $urandom_range(30000, 65535);
            send(OP_CONS, sid, pick_attr(), lo, hi, $urandom_range(0, 65535),
                 i == n - 1);
        end
    endtask

    task automatic send_publication(input int k, input bit interleave);
        for (int i = 0; i < k; i++)
        begin
            send(OP_PAIR, $urandom_range(0, MAX_SUBS - 1), pick_attr(),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), i == k - 1);
            // Store a subscription while the publication is still open.
            if (interleave && i == 0 && k > 1)
                send_subscription($urandom_range(1, 3), pick_sub());
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int pick;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every operation, ignored codes.
        send(OP_FREQ, 0, 0, 0, 0, 0, 0);
        send(OP_FREQ, 1023, 31, 65535, 65535, 65535, 1);
        send(OP_FREQ, 0, 3, 0, 0, 0, 0);
        send(OP_NONE, 1023, 31, 65535, 65535, 65535, 1);
        send(OP_CONS, 0, 0, 0, 65535, 0, 1);
        send(OP_CONS, 1023, 31, 65535, 0, 0, 1);
        send(OP_CONS, 5, 17, 100, 200, 0, 0);
        send(OP_CONS, 5, 1, 0, 65535, 0, 0);
        send(OP_CONS, 5, 3, 10, 10, 0, 1);
        send(OP_PAIR, 0, 0, 0, 0, 0, 0);
        send(OP_PAIR, 0, 31, 0, 0, 65535, 0);
        send(OP_PAIR, 0, 17, 0, 0, 150, 0);
        send(OP_PAIR, 0, 1, 0, 0, 7, 0);
        send(OP_PAIR, 0, 3, 0, 0, 10, 1);
        // Reuse an identifier: old entries keep feeding the same counter.
        send(OP_CONS, 0, 16, 0, 65535, 0, 1);
        send(OP_PAIR, 0, 0, 0, 0, 65535, 0);
        send(OP_PAIR, 0, 16, 0, 0, 300, 1);
        // Pair with an empty bucket, lone pair publication.
        send(OP_PAIR, 0, 9, 0, 0, 1, 1);
        send(OP_NONE, 0, 0, 0, 0, 0, 0);

        // Random: mostly well-formed subscriptions and publications.
        while (sent < 1250)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                repeat ($urandom_range(1, 4))
                    send(OP_FREQ, pick_sub(), pick_attr(), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         1'($urandom_range(0, 1)));
            else if (pick < 47)
                send_subscription($urandom_range(1, 4), pick_sub());
            else if (pick < 50)
                // Overfull subscription: rejected.
                send_subscription($urandom_range(MAX_CONS + 1, MAX_CONS + 2), pick_sub());
            else if (pick < 92)
                send_publication($urandom_range(1, 6), $urandom_range(0, 9) == 0);
            else
                send(OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 31),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
            steady = $urandom_range(0, 19) == 0;
            // While sent lies between 601 and 619, hold off until all outstanding results have arrived.
            if (sent > 600 && sent < 620)
                wait_drained();
        end

        send_publication(3, 0);
        send_publication(2, 0);

        in_valid <= 1'b0;
        wait_drained();
        repeat (300) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
